/* src/trld_pkg.sv */
package trld_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int LEVEL_WIDTH  = 16;
    localparam int FRAME_WIDTH  = 32;
    localparam int CFG_IDX_W    = 3;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WAIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY     = 3'd4;

    // event kinds
    localparam logic EV_MATCHED   = 1'b0;
    localparam logic EV_UNMATCHED = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] trigger_sample;
        logic signed [SAMPLE_WIDTH-1:0] response_sample;
        logic                           final_frame;
    } t_frame;

    typedef struct packed {
        logic                   event_kind;
        logic [FRAME_WIDTH-1:0] latency_frames;
        logic [FRAME_WIDTH-1:0] trigger_number;
        logic                   last_of_run;
    } t_result;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] trigger_level;
        logic [LEVEL_WIDTH-1:0] response_level;
        logic [FRAME_WIDTH-1:0] min_wait_frames;
        logic [FRAME_WIDTH-1:0] max_wait_frames;
        logic [FRAME_WIDTH-1:0] holdoff_frames;
    } t_cfg;

    // up to two results per frame
    typedef struct packed {
        logic [1:0] count;
        t_result    item0;
        t_result    item1;
    } t_push;

    // absolute value, one bit wider so the most negative sample fits
    function automatic logic [SAMPLE_WIDTH:0] magnitude(
        input logic signed [SAMPLE_WIDTH-1:0] s
    );
        logic [SAMPLE_WIDTH:0] ext;
        ext = {s[SAMPLE_WIDTH-1], s};
        return s[SAMPLE_WIDTH-1] ? (~ext + 1'b1) : ext;
    endfunction

endpackage

/* src/trld_cfg.sv */
module trld_cfg
    import trld_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRAME_WIDTH-1:0] i_cfg_data,
    output logic                   o_cfg_ready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_level   <= LEVEL_WIDTH'(16384);
            r_cfg.response_level  <= LEVEL_WIDTH'(3277);
            r_cfg.min_wait_frames <= FRAME_WIDTH'(48);
            r_cfg.max_wait_frames <= FRAME_WIDTH'(9600);
            r_cfg.holdoff_frames  <= FRAME_WIDTH'(14400);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_LEVEL:  r_cfg.trigger_level   <= i_cfg_data[LEVEL_WIDTH-1:0];
                CFG_RESPONSE_LEVEL: r_cfg.response_level  <= i_cfg_data[LEVEL_WIDTH-1:0];
                CFG_MIN_WAIT:       r_cfg.min_wait_frames <= i_cfg_data;
                CFG_MAX_WAIT:       r_cfg.max_wait_frames <= i_cfg_data;
                CFG_REFRACTORY:     r_cfg.holdoff_frames  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* src/trld_core.sv */
module trld_core
    import trld_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_frame_valid,
    input  t_frame i_frame,
    input  logic   i_room,
    output logic   o_frame_stall,
    output t_push  o_push
);

    localparam int WIDE = (COUNT_WIDTH > FRAME_WIDTH) ? COUNT_WIDTH : FRAME_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // input register
    logic   r_in_valid;
    t_frame r_in;

    // detector state
    logic                   r_prev_above;
    logic                   r_seen;
    logic [COUNT_WIDTH-1:0] r_since;
    logic                   r_pending;
    logic [COUNT_WIDTH-1:0] r_total;

    logic                   n_prev_above;
    logic                   n_seen;
    logic [COUNT_WIDTH-1:0] n_since;
    logic                   n_pending;
    logic [COUNT_WIDTH-1:0] n_total;

    logic                    advance;
    logic [SAMPLE_WIDTH:0]   tmag;
    logic [SAMPLE_WIDTH:0]   rmag;
    logic                    hit;
    logic                    above;
    logic [COUNT_WIDTH-1:0]  d;
    logic [WIDE-1:0]         d_w;
    logic [WIDE-1:0]         min_w;
    logic [WIDE-1:0]         max_w;
    logic [WIDE-1:0]         refr_w;
    logic                    empty_win;
    logic                    match;
    logic                    over;
    logic                    pend_a;
    logic                    fire;
    logic                    match0;
    logic                    over0;
    logic                    pend_b;
    logic [COUNT_WIDTH-1:0]  total_inc;
    logic [3:0]              ev;
    t_result                 cand [4];
    t_result                 res0;
    t_result                 res1;
    logic                    got0;
    logic                    got1;

    assign advance       = r_in_valid && i_room;
    assign o_frame_stall = r_in_valid && !i_room;

    assign tmag  = magnitude(r_in.trigger_sample);
    assign rmag  = magnitude(r_in.response_sample);
    assign hit   = rmag >= {1'b0, i_cfg.response_level};
    assign above = tmag >= {1'b0, i_cfg.trigger_level};

    // offset of this frame from the last trigger, saturating
    assign d = !r_seen ? '0 : ((r_since == COUNT_MAX) ? COUNT_MAX : r_since + 1'b1);

    assign d_w    = WIDE'(d);
    assign min_w  = WIDE'(i_cfg.min_wait_frames);
    assign max_w  = WIDE'(i_cfg.max_wait_frames);
    assign refr_w = WIDE'(i_cfg.holdoff_frames);

    assign empty_win = min_w > max_w;

    // open search looks at this frame first
    assign match  = (d_w >= min_w) && (d_w <= max_w) && hit;
    assign over   = (d_w >= max_w) || empty_win;
    assign pend_a = r_pending && !match && !over;

    assign fire = (i_cfg.trigger_level != '0) && above && !r_prev_above &&
                  (!r_seen || d_w >= refr_w);

    assign total_inc = (r_total == COUNT_MAX) ? COUNT_MAX : r_total + 1'b1;

    // offset-0 check of a fresh trigger
    assign match0 = (i_cfg.min_wait_frames == '0) && hit;
    assign over0  = (i_cfg.max_wait_frames == '0) || empty_win;

    assign pend_b = fire ? !(match0 || over0) : pend_a;

    assign n_total      = fire ? total_inc : r_total;
    assign n_prev_above = r_in.final_frame ? 1'b0 : above;
    assign n_seen       = r_in.final_frame ? 1'b0 : (r_seen || fire);
    assign n_since      = (r_in.final_frame || fire) ? '0 : d;
    assign n_pending    = r_in.final_frame ? 1'b0 : pend_b;

    // candidate events in model order
    always_comb begin
        ev[0] = r_pending && (match || over);
        ev[1] = fire && pend_a;
        ev[2] = fire && (match0 || over0);
        ev[3] = r_in.final_frame && pend_b;

        cand[0].event_kind     = match ? EV_MATCHED : EV_UNMATCHED;
        cand[0].latency_frames = match ? d_w[FRAME_WIDTH-1:0] : '0;
        cand[0].trigger_number = FRAME_WIDTH'(WIDE'(r_total));
        cand[0].last_of_run    = 1'b0;

        cand[1].event_kind     = EV_UNMATCHED;
        cand[1].latency_frames = '0;
        cand[1].trigger_number = FRAME_WIDTH'(WIDE'(r_total));
        cand[1].last_of_run    = 1'b0;

        cand[2].event_kind     = match0 ? EV_MATCHED : EV_UNMATCHED;
        cand[2].latency_frames = '0;
        cand[2].trigger_number = FRAME_WIDTH'(WIDE'(n_total));
        cand[2].last_of_run    = 1'b0;

        cand[3].event_kind     = EV_UNMATCHED;
        cand[3].latency_frames = '0;
        cand[3].trigger_number = FRAME_WIDTH'(WIDE'(n_total));
        cand[3].last_of_run    = 1'b0;
    end

    // pack the (at most two) events into slots
    always_comb begin
        res0 = cand[0];
        res1 = cand[0];
        got0 = 1'b0;
        got1 = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (ev[i]) begin
                if (!got0) begin
                    res0 = cand[i];
                    got0 = 1'b1;
                end else if (!got1) begin
                    res1 = cand[i];
                    got1 = 1'b1;
                end
            end
        end
        if (got1) begin
            res1.last_of_run = 1'b1;
        end else begin
            res0.last_of_run = 1'b1;
        end
        o_push.count = advance ? ({1'b0, got0} + {1'b0, got1}) : 2'd0;
        o_push.item0 = res0;
        o_push.item1 = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prev_above <= 1'b0;
            r_seen       <= 1'b0;
            r_since      <= '0;
            r_pending    <= 1'b0;
            r_total      <= '0;
        end else begin
            if (!o_frame_stall) begin
                r_in_valid <= i_frame_valid;
            end
            if (advance) begin
                r_prev_above <= n_prev_above;
                r_seen       <= n_seen;
                r_since      <= n_since;
                r_pending    <= n_pending;
                r_total      <= r_in.final_frame ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_frame_stall && i_frame_valid) begin
            r_in <= i_frame;
        end
    end

endmodule

/* src/trld_fifo.sv */
module trld_fifo
    import trld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_count;
    logic               pop;
    logic [PTR_W-1:0]   wr_next;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    // a frame may leave two beats, so keep two slots free
    assign o_room  = r_count <= (PTR_W+1)'(DEPTH - 2);
    assign wr_next = r_wr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.count);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + (PTR_W+1)'(i_push.count) - (PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.item1;
        end
    end

endmodule

/* src/trigger_response_latency_detector.sv */
// Trigger-to-response latency detector. Each input beat is one audio frame
// (trigger sample, response sample, end-of-capture mark). A trigger is a rising
// crossing of trigger_level by |trigger_sample|, honoured only once
// holdoff_frames have passed since the previous one; the first frame from
// it, min_wait_frames..max_wait_frames on, with |response_sample| at or above
// response_level gives a matched beat carrying the latency. Window expiry, a
// new trigger over an open search, or the end of capture gives an unmatched
// beat. Rate: one frame per cycle while the queue has room; each frame passes
// the input register, then the compare/update stage writing a four-entry queue.
// A frame yields zero, one or two result beats; the queue drains one beat per
// unstalled cycle, so frames are taken every cycle as long as they average
// no more than one result each; input stalls with fewer than two slots free.
// Configuration writes are always ready and must be made while idle.
module trigger_response_latency_detector
    import trld_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // frame input
    input  logic                   i_in_valid,
    input  t_frame                 i_in_data,
    output logic                   o_in_stall,
    // event output
    output logic                   o_out_valid,
    output t_result                o_out_data,
    input  logic                   i_out_stall,
    // register writes
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRAME_WIDTH-1:0] i_cfg_data,
    output logic                   o_cfg_ready
);

    t_cfg  cfg;
    t_push push;
    logic  room;

    // settings registers
    trld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // frame register, detector state and event generation
    trld_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_frame_valid (i_in_valid),
        .i_frame       (i_in_data),
        .i_room        (room),
        .o_frame_stall (o_in_stall),
        .o_push        (push)
    );

    // result queue, one beat out per cycle unless the receiver stalls
    trld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trld_pkg::*;

    // Outcome of looking at one frame offset inside an open response search
    typedef enum logic [1:0] {
        WIN_OPEN,   // keep looking
        WIN_HIT,    // response found inside the window
        WIN_MISSED  // window closed (or empty) without a response
    } t_window;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_frame                 i_in_data   = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_result                o_out_data;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_TRIGGER_LEVEL;
    logic [FRAME_WIDTH-1:0] i_cfg_data  = '0;
    logic                   o_cfg_ready;

    trigger_response_latency_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // 2 ns period
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_frame  frame_q[$];     // frames waiting to be offered, head is on the bus
    t_result events_due[$];  // predicted events, oldest first
    int      mismatches    = 0;
    int      frames_taken  = 0;
    logic    in_taken      = 1'b0;  // bus beat was accepted at the last rising edge

    // Predictor copy of the registers and the capture state
    t_cfg        cfg_m;
    logic        prev_above;
    logic        trig_seen;
    logic [31:0] since_trig;
    logic        search_open;
    logic [31:0] trig_count;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [SAMPLE_WIDTH:0] abs_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
        logic [SAMPLE_WIDTH:0] wide;
        wide = {s[SAMPLE_WIDTH-1], s};
        if (s[SAMPLE_WIDTH-1])
            wide = -wide;   // -32768 becomes 32768, hence the extra bit
        return wide;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic t_window window_check(input logic [31:0] off, input logic hit);
        if (off >= cfg_m.min_wait_frames && off <= cfg_m.max_wait_frames && hit)
            return WIN_HIT;
        if (off >= cfg_m.max_wait_frames || cfg_m.min_wait_frames > cfg_m.max_wait_frames)
            return WIN_MISSED;
        return WIN_OPEN;
    endfunction

    function automatic t_result make_event(input logic kind, input logic [31:0] lat);
        t_result r;
        r.event_kind     = kind;
        r.latency_frames = lat;
        r.trigger_number = trig_count;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    task automatic clear_capture();
        prev_above  = 1'b0;
        trig_seen   = 1'b0;
        since_trig  = '0;
        search_open = 1'b0;
        trig_count  = '0;
    endtask

    // Work out the events caused by one accepted frame and queue them
    task automatic predict_frame(input t_frame f);
        t_result     outs[2];
        int          n;
        logic        hit;
        logic        above;
        logic        fire;
        logic [31:0] off;
        t_window     w;
        n     = 0;
        hit   = abs_sample(f.response_sample) >= {1'b0, cfg_m.response_level};
        above = abs_sample(f.trigger_sample) >= {1'b0, cfg_m.trigger_level};
        off   = trig_seen ? sat_inc(since_trig) : '0;

        // open search looks at this frame first
        if (search_open) begin
            w = window_check(off, hit);
            if (w != WIN_OPEN) begin
                outs[n] = make_event(w == WIN_HIT ? EV_MATCHED : EV_UNMATCHED,
                                     w == WIN_HIT ? off : 32'd0);
                n++;
                search_open = 1'b0;
            end
        end

        // level 0 never fires: the magnitude before the first frame is never below it
        fire = (cfg_m.trigger_level != '0) && above && !prev_above &&
               (!trig_seen || off >= cfg_m.holdoff_frames);
        if (fire) begin
            // a new trigger closes a still-open search as unmatched
            if (search_open) begin
                outs[n] = make_event(EV_UNMATCHED, 32'd0);
                n++;
                search_open = 1'b0;
            end
            trig_count = sat_inc(trig_count);
            trig_seen  = 1'b1;
            off        = '0;
            w = window_check(32'd0, hit);
            if (w == WIN_OPEN) begin
                search_open = 1'b1;
            end else begin
                outs[n] = make_event(w == WIN_HIT ? EV_MATCHED : EV_UNMATCHED, 32'd0);
                n++;
            end
        end

        prev_above = above;
        since_trig = off;

        // end of capture: flush the open search, then back to the reset state
        if (f.final_frame) begin
            if (search_open) begin
                outs[n] = make_event(EV_UNMATCHED, 32'd0);
                n++;
            end
            clear_capture();
        end

        for (int k = 0; k < n; k++) begin
            if (k == n - 1)
                outs[k].last_of_run = 1'b1;
            events_due.push_back(outs[k]);
        end
    endtask

    function automatic int field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted frames and result beats, all seen
    // at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        in_taken <= i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            cfg_m.trigger_level   = 16'd16384;
            cfg_m.response_level  = 16'd3277;
            cfg_m.min_wait_frames = 32'd48;
            cfg_m.max_wait_frames = 32'd9600;
            cfg_m.holdoff_frames  = 32'd14400;
            clear_capture();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TRIGGER_LEVEL:  cfg_m.trigger_level   = i_cfg_data[LEVEL_WIDTH-1:0];
                    CFG_RESPONSE_LEVEL: cfg_m.response_level  = i_cfg_data[LEVEL_WIDTH-1:0];
                    CFG_MIN_WAIT:       cfg_m.min_wait_frames = i_cfg_data;
                    CFG_MAX_WAIT:       cfg_m.max_wait_frames = i_cfg_data;
                    CFG_REFRACTORY:     cfg_m.holdoff_frames  = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !o_in_stall) begin
                predict_frame(i_in_data);
                void'(frame_q.pop_front());
                frames_taken++;
            end

            if (o_out_valid && !i_out_stall) begin
                if (events_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected event, expected none, got %p",
                             $time, o_out_data);
                end else begin
                    want = events_due.pop_front();
                    mismatches += field_bad("event_kind", want.event_kind,
                                            o_out_data.event_kind);
                    mismatches += field_bad("latency_frames", want.latency_frames,
                                            o_out_data.latency_frames);
                    mismatches += field_bad("trigger_number", want.trigger_number,
                                            o_out_data.trigger_number);
                    mismatches += field_bad("last_of_run", want.last_of_run,
                                            o_out_data.last_of_run);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers frame_q in bursts with random gaps. A beat stays on the
    // bus unchanged until it is taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (frame_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= frame_q[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // a quarter of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: a pattern that switches mode now and then, plus one
    // long hold-off in mid-run while frames are still queued, so the result
    // queue fills and the input side has to stall.
    // ------------------------------------------------------------------
    int stall_mode     = 0;
    int mode_left      = 0;
    int hold_left      = 0;
    int stall_phase    = 0;
    bit long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!long_hold_done && frames_taken >= 500 && frame_q.size() > 50) begin
            hold_left      = 300;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            stall_phase = (stall_phase + 1) % 5;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;                        // free running
                1:       i_out_stall <= ($urandom_range(0, 3) == 0); // light
                2:       i_out_stall <= ($urandom_range(0, 3) != 0); // heavy
                default: i_out_stall <= (stall_phase < 2);           // periodic
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_frame(input logic signed [15:0] trig, input logic signed [15:0] resp,
                              input logic fin);
        t_frame f;
        f.trigger_sample  = trig;
        f.response_sample = resp;
        f.final_frame     = fin;
        frame_q.push_back(f);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] tl, input logic [31:0] rl, input logic [31:0] mn,
                            input logic [31:0] mx, input logic [31:0] rf);
        write_reg(CFG_TRIGGER_LEVEL, tl);
        write_reg(CFG_RESPONSE_LEVEL, rl);
        write_reg(CFG_MIN_WAIT, mn);
        write_reg(CFG_MAX_WAIT, mx);
        write_reg(CFG_REFRACTORY, rf);
    endtask

    // Everything sent and answered; frames that give no event may still be in
    // the pipeline, so wait for them to leave it as well.
    task automatic wait_idle();
        while (frame_q.size() != 0 || events_due.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Sample whose magnitude is at/above level, or below it, random sign
    function automatic logic signed [15:0] sample_at(input logic [16:0] level, input bit above);
        logic [16:0] m;
        if (!above && level == 0)
            return 16'($urandom);    // nothing lies below a zero level
        m = above ? 17'($urandom_range(32768, level)) : 17'($urandom_range(level - 1, 0));
        if (m == 17'd32768)
            return 16'sh8000;
        return $urandom_range(0, 1) ? 16'(-m) : m[15:0];
    endfunction

    // Mostly well-formed trigger pulses (quiet stretch, then a few loud frames)
    // with sparse response spikes; a tenth of the frames are pure noise.
    task automatic random_frames(input int count);
        int     hi_left;
        int     lo_left;
        bit     tr_above;
        t_frame f;
        hi_left = 0;
        lo_left = 0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                f = t_frame'({32'($urandom), 1'($urandom_range(0, 1))});
            end else begin
                if (hi_left > 0) begin
                    tr_above = 1'b1;
                    hi_left--;
                end else if (lo_left > 0) begin
                    tr_above = 1'b0;
                    lo_left--;
                end else begin
                    tr_above = 1'b0;
                    lo_left  = $urandom_range(0, 40);
                    hi_left  = $urandom_range(1, 4);
                end
                f.trigger_sample  = sample_at({1'b0, cfg_m.trigger_level}, tr_above);
                f.response_sample = sample_at({1'b0, cfg_m.response_level},
                                              $urandom_range(0, 5) == 0);
                f.final_frame     = ($urandom_range(0, 119) == 0);
            end
            frame_q.push_back(f);
        end
    endtask

    initial begin
        logic [31:0] mn;
        logic [31:0] mx;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: search left open, then closed by end of capture
        push_frame(16'sd20000, 16'sd4000, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b1);
        wait_idle();

        // Hold-off below max wait; response on the trigger frame counts
        set_regs(32'd1000, 32'd500, 32'd0, 32'd3, 32'd2);
        push_frame(16'sd2000, 16'sd600, 1'b0);      // matched at offset 0
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(16'sh8000, 16'sd0, 1'b0);        // most negative trigger sample
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(16'sd1500, 16'sd0, 1'b0);        // retrigger over open search: one unmatched beat
        push_frame(16'sd0, 16'sd32767, 1'b0);       // matched on the frame after the retrigger
        push_frame(16'sd5000, 16'sd0, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b1);           // end of capture, search flushed
        push_frame(16'sd32767, 16'sh8000, 1'b0);    // fresh capture, count restarts
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(16'sd2000, 16'sd0, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b1);           // window runs out on the last frame
        wait_idle();

        // Top trigger level (only -32768 reaches it), zero response level,
        // empty window, hold-off at its maximum
        set_regs(32'd32768, 32'd0, 32'd5, 32'd2, 32'hFFFF_FFFF);
        push_frame(16'sh8000, 16'sd0, 1'b0);
        push_frame(16'sd32767, 16'sd1, 1'b0);
        push_frame(16'sh8000, -16'sd1, 1'b1);       // held off
        wait_idle();

        // Zero trigger level: nothing may fire; widest window values
        set_regs(32'd0, 32'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        push_frame(16'sh8000, 16'sh8000, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b1);
        wait_idle();

        // Single-offset window at 0, lowest trigger level
        set_regs(32'd1, 32'd32768, 32'd0, 32'd0, 32'd0);
        push_frame(16'sd1, 16'sd1, 1'b0);           // window shut on the trigger frame
        push_frame(-16'sd1, 16'sh8000, 1'b0);       // still above: no new trigger
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(-16'sd2, 16'sh8000, 1'b1);
        wait_idle();

        // Random phases, each under its own register setting
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: set_regs($urandom_range(1, 32768), $urandom_range(1, 32768),
                            $urandom_range(0, 4), $urandom_range(4, 30), $urandom_range(0, 40));
                1: set_regs(32'd32768, 32'd1, 32'd0, 32'd0, 32'd0);
                2: set_regs(32'd1, 32'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            $urandom_range(0, 20));
                3: begin
                    // hold-off at or beyond the window, the usual setup
                    mn = $urandom_range(0, 6);
                    mx = $urandom_range(mn, 24);
                    set_regs($urandom_range(1, 32768), $urandom_range(1, 32768), mn, mx,
                             mx + $urandom_range(0, 20));
                end
                4: set_regs($urandom_range(1, 32768), $urandom_range(1, 32768),
                            $urandom_range(10, 40), $urandom_range(0, 9), $urandom_range(0, 30));
                5: set_regs(32'd0, $urandom_range(1, 32768), 32'd0, 32'd10, 32'd0);
                default: set_regs($urandom_range(1, 32768), 32'd0, $urandom_range(0, 5),
                                  $urandom_range(5, 20), $urandom_range(0, 30));
            endcase
            random_frames(p == 5 ? 60 : 160);
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/trld_pkg.sv
src/trld_cfg.sv
src/trld_core.sv
src/trld_fifo.sv
src/trigger_response_latency_detector.sv
tb/tb.sv
